/* rtl/core/cstep_pkg.sv */
package cstep_pkg;

    localparam int TABLE_ROWS_DEF    = 256;
    localparam int ROW_LENGTH_DEF    = 64;
    localparam int CHIRP_SLOTS_DEF   = 128;
    localparam int QUARTER_CHIRP_DEF = 12;
    localparam int DATA_CHIRP_DEF    = 13;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    localparam logic [15:0] MOD_DEV_BITS = 16'h0040;
    localparam logic [31:0] START_TIME   = 32'd200;
    localparam logic [6:0]  MAX_STEPS    = 7'd64;

    typedef enum logic [1:0] {
        OP_TICK        = 2'd0,
        OP_ROW_WRITE   = 2'd1,
        OP_TABLE_WRITE = 2'd2,
        OP_START       = 2'd3
    } op_t;

    localparam logic [CFG_IDX_W-1:0] CFG_NORMAL_WHOLE    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_NORMAL_FRACTION = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_NORMAL_STEPS    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_QUARTER_WHOLE   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_QUARTER_FRACTION = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_QUARTER_STEPS   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_FRACTION_MOD    = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_CHIRP_COUNT     = 3'd7;

    typedef struct packed {
        logic [23:0] step_whole;
        logic [15:0] step_fraction;
        logic [15:0] modulus;
    } step_cfg_t;

    typedef struct packed {
        logic        frame_valid;
        logic [15:0] spi_word;
        logic [31:0] compare_time;
        logic        done_res;
    } result_t;

endpackage

/* rtl/core/cstep_timing.sv */
module cstep_timing (
    input  logic [31:0]          next_time,
    input  logic [15:0]          fraction_acc,
    input  cstep_pkg::step_cfg_t step_cfg,
    output logic [31:0]          next_time_adv,
    output logic [15:0]          fraction_adv
);

    logic [16:0] acc_sum;
    logic [16:0] acc_wrapped;
    logic        carry;

    assign acc_sum     = {1'b0, fraction_acc} + {1'b0, step_cfg.step_fraction};
    assign carry       = (acc_sum >= {1'b0, step_cfg.modulus});
    assign acc_wrapped = acc_sum - {1'b0, step_cfg.modulus};

    assign fraction_adv  = carry ? acc_wrapped[15:0] : acc_sum[15:0];
    assign next_time_adv = next_time + {8'd0, step_cfg.step_whole} + {31'd0, carry};

endmodule

/* rtl/core/chirp_step_sequencer.sv */
// channel | direction | handshake             | payload
// in      | input     | in_valid / in_ready   | operation, address, data
// out     | output    | out_valid / out_ready | frame_valid, spi_word, compare_time, done_res
// cfg     | input     | cfg_write             | cfg_index, cfg_data
// Loads, idle ticks and ticks within a chirp are handled in ST_READY alone, as is the tick that ends the packet;
// a start item and a tick that moves on to a new chirp also pass through ST_ROW_FETCH, as the start-row
// memory read must land before the offset table read.
// Both tables are synchronous memories with one write port and one read port, one read per cycle each.
// Reset clears counters and control registers at once; tables need no clearing pass.
// A two-entry result queue lets items enter while a result waits; in_ready drops when full.
module chirp_step_sequencer #(
    parameter int TABLE_ROWS    = cstep_pkg::TABLE_ROWS_DEF,
    parameter int ROW_LENGTH    = cstep_pkg::ROW_LENGTH_DEF,
    parameter int CHIRP_SLOTS   = cstep_pkg::CHIRP_SLOTS_DEF,
    parameter int QUARTER_CHIRP = cstep_pkg::QUARTER_CHIRP_DEF,
    parameter int DATA_CHIRP    = cstep_pkg::DATA_CHIRP_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_write,
    input  logic [cstep_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [cstep_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic [1:0]                       operation,
    input  logic [13:0]                      address,
    input  logic [15:0]                      data,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic                             frame_valid,
    output logic [15:0]                      spi_word,
    output logic [31:0]                      compare_time,
    output logic                             done_res
);

    localparam int TABLE_SIZE = TABLE_ROWS * ROW_LENGTH;
    localparam int TAW = (TABLE_SIZE > 1) ? $clog2(TABLE_SIZE) : 1;
    localparam int CAW = (CHIRP_SLOTS > 1) ? $clog2(CHIRP_SLOTS) : 1;

    typedef enum logic {ST_READY, ST_ROW_FETCH} state_t;

    // configuration
    logic [23:0] normal_whole_reg, quarter_whole_reg;
    logic [15:0] normal_frac_reg, quarter_frac_reg, modulus_reg;
    logic [6:0]  normal_steps_reg, quarter_steps_reg;
    logic [7:0]  chirp_count_reg;

    // control state
    state_t      state_reg, state_next;
    logic [31:0] next_time_reg, next_time_next;
    logic [15:0] fraction_reg, fraction_next;
    logic [5:0]  step_index_reg, step_index_next;
    logic [7:0]  chirp_index_reg, chirp_index_next;
    logic [7:0]  current_row_reg, current_row_next;
    logic        quarter_reg, quarter_next;
    logic        running_reg, running_next;
    logic        row_zero_reg, row_zero_next;
    logic        off_zero_reg, off_zero_next;

    // result queue
    cstep_pkg::result_t slot0_reg, slot1_reg, res;
    logic [1:0]         count_reg;

    // memories
    logic [5:0] offset_mem [TABLE_SIZE];
    logic [7:0] rows_mem [CHIRP_SLOTS];
    logic [5:0] tbl_rdata_reg;
    logic [7:0] rows_rdata_reg;

    logic        in_accept, out_pop;
    logic        tbl_we, tbl_re, rows_we, rows_re;
    logic [7:0]  rd_row, rows_raddr;
    logic [5:0]  rd_step;
    logic [14:0] tbl_lin;
    logic        tbl_oor;
    logic [5:0]  cur_offset;
    logic [7:0]  fetched_row;

    cstep_pkg::step_cfg_t step_cfg;
    logic [31:0] time_adv;
    logic [15:0] frac_adv;
    logic [6:0]  steps_sel, steps_eff, step_inc;
    logic [7:0]  chirp_inc;

    assign in_ready  = (state_reg == ST_READY) && (count_reg != 2'd2);
    assign in_accept = in_valid && in_ready;
    assign out_valid = (count_reg != 2'd0);
    assign out_pop   = out_valid && out_ready;

    assign frame_valid  = slot0_reg.frame_valid;
    assign spi_word     = slot0_reg.spi_word;
    assign compare_time = slot0_reg.compare_time;
    assign done_res     = slot0_reg.done_res;

    assign cur_offset  = off_zero_reg ? 6'd0 : tbl_rdata_reg;
    assign fetched_row = row_zero_reg ? 8'd0 : rows_rdata_reg;

    assign step_cfg.step_whole    = quarter_reg ? quarter_whole_reg : normal_whole_reg;
    assign step_cfg.step_fraction = quarter_reg ? quarter_frac_reg : normal_frac_reg;
    assign step_cfg.modulus       = modulus_reg;
    assign steps_sel = quarter_reg ? quarter_steps_reg : normal_steps_reg;
    assign steps_eff = (steps_sel == 7'd0) ? 7'd1 :
                       (steps_sel > cstep_pkg::MAX_STEPS) ? cstep_pkg::MAX_STEPS : steps_sel;
    assign step_inc  = {1'b0, step_index_reg} + 7'd1;
    assign chirp_inc = chirp_index_reg + 8'd1;

    cstep_timing u_timing (
        .next_time     (next_time_reg),
        .fraction_acc  (fraction_reg),
        .step_cfg      (step_cfg),
        .next_time_adv (time_adv),
        .fraction_adv  (frac_adv)
    );

    assign tbl_lin = 15'(rd_row) * 15'(ROW_LENGTH) + 15'(rd_step);
    assign tbl_oor = ({1'b0, rd_row} >= 9'(TABLE_ROWS)) || ({1'b0, rd_step} >= 7'(ROW_LENGTH));

    assign tbl_we  = in_accept && (cstep_pkg::op_t'(operation) == cstep_pkg::OP_TABLE_WRITE)
                     && ({1'b0, address} < 15'(TABLE_SIZE));
    assign rows_we = in_accept && (cstep_pkg::op_t'(operation) == cstep_pkg::OP_ROW_WRITE)
                     && (address < 14'(CHIRP_SLOTS));

    always_comb
    begin
        state_next       = state_reg;
        next_time_next   = next_time_reg;
        fraction_next    = fraction_reg;
        step_index_next  = step_index_reg;
        chirp_index_next = chirp_index_reg;
        current_row_next = current_row_reg;
        quarter_next     = quarter_reg;
        running_next     = running_reg;
        row_zero_next    = row_zero_reg;
        off_zero_next    = off_zero_reg;
        tbl_re           = 1'b0;
        rows_re          = 1'b0;
        rd_row           = current_row_reg;
        rd_step          = step_index_reg;
        rows_raddr       = chirp_inc;
        res.frame_valid  = 1'b0;
        res.spi_word     = 16'd0;
        res.done_res     = 1'b0;

        unique case (state_reg)
            ST_READY:
            begin
                if (in_accept)
                begin
                    unique case (cstep_pkg::op_t'(operation))
                        cstep_pkg::OP_START:
                        begin
                            step_index_next  = 6'd0;
                            chirp_index_next = 8'd0;
                            quarter_next     = 1'b0;
                            next_time_next   = cstep_pkg::START_TIME;
                            fraction_next    = 16'd0;
                            running_next     = 1'b1;
                            rows_re          = 1'b1;
                            rows_raddr       = 8'd0;
                            row_zero_next    = 1'b0;
                            state_next       = ST_ROW_FETCH;
                        end
                        cstep_pkg::OP_TICK:
                        begin
                            if (running_reg)
                            begin
                                res.frame_valid = 1'b1;
                                res.spi_word    = {3'd0, cur_offset, 7'd0} | cstep_pkg::MOD_DEV_BITS;
                                next_time_next  = time_adv;
                                fraction_next   = frac_adv;
                                if (step_inc >= steps_eff)
                                begin
                                    step_index_next  = 6'd0;
                                    chirp_index_next = chirp_inc;
                                    if (chirp_inc == 8'(QUARTER_CHIRP))
                                    begin
                                        quarter_next = 1'b1;
                                    end
                                    else if (chirp_inc == 8'(DATA_CHIRP))
                                    begin
                                        quarter_next = 1'b0;
                                    end
                                    else if (chirp_inc == chirp_count_reg)
                                    begin
                                        running_next = 1'b0;
                                        res.done_res = 1'b1;
                                    end
                                    if (!res.done_res)
                                    begin
                                        rows_re       = 1'b1;
                                        row_zero_next = ({1'b0, chirp_inc} >= 9'(CHIRP_SLOTS));
                                        state_next    = ST_ROW_FETCH;
                                    end
                                end
                                else
                                begin
                                    step_index_next = step_inc[5:0];
                                    rd_step         = step_inc[5:0];
                                    tbl_re          = 1'b1;
                                    off_zero_next   = tbl_oor;
                                end
                            end
                        end
                        cstep_pkg::OP_ROW_WRITE, cstep_pkg::OP_TABLE_WRITE:
                        begin
                        end
                    endcase
                end
            end
            ST_ROW_FETCH:
            begin
                current_row_next = fetched_row;
                rd_row           = fetched_row;
                rd_step          = 6'd0;
                tbl_re           = 1'b1;
                off_zero_next    = tbl_oor;
                state_next       = ST_READY;
            end
        endcase

        res.compare_time = next_time_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_READY;
            next_time_reg   <= cstep_pkg::START_TIME;
            fraction_reg    <= 16'd0;
            step_index_reg  <= 6'd0;
            chirp_index_reg <= 8'd0;
            current_row_reg <= 8'd0;
            quarter_reg     <= 1'b0;
            running_reg     <= 1'b0;
            row_zero_reg    <= 1'b1;
            off_zero_reg    <= 1'b1;
        end
        else
        begin
            state_reg       <= state_next;
            next_time_reg   <= next_time_next;
            fraction_reg    <= fraction_next;
            step_index_reg  <= step_index_next;
            chirp_index_reg <= chirp_index_next;
            current_row_reg <= current_row_next;
            quarter_reg     <= quarter_next;
            running_reg     <= running_next;
            row_zero_reg    <= row_zero_next;
            off_zero_reg    <= off_zero_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= 2'd0;
        end
        else
        begin
            case (count_reg)
                2'd0:
                begin
                    if (in_accept)
                    begin
                        count_reg <= 2'd1;
                    end
                end
                2'd1:
                begin
                    if (in_accept && !out_pop)
                    begin
                        count_reg <= 2'd2;
                    end
                    else if (!in_accept && out_pop)
                    begin
                        count_reg <= 2'd0;
                    end
                end
                default:
                begin
                    if (out_pop)
                    begin
                        count_reg <= 2'd1;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        case (count_reg)
            2'd0:
            begin
                if (in_accept)
                begin
                    slot0_reg <= res;
                end
            end
            2'd1:
            begin
                if (in_accept && out_pop)
                begin
                    slot0_reg <= res;
                end
                else if (in_accept)
                begin
                    slot1_reg <= res;
                end
            end
            default:
            begin
                if (out_pop)
                begin
                    slot0_reg <= slot1_reg;
                end
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (tbl_we)
        begin
            offset_mem[address[TAW-1:0]] <= data[12:7];
        end
        if (tbl_re)
        begin
            tbl_rdata_reg <= offset_mem[tbl_lin[TAW-1:0]];
        end
    end

    always_ff @(posedge clk)
    begin
        if (rows_we)
        begin
            rows_mem[address[CAW-1:0]] <= data[7:0];
        end
        if (rows_re)
        begin
            rows_rdata_reg <= rows_mem[rows_raddr[CAW-1:0]];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            normal_whole_reg  <= 24'd1000;
            normal_frac_reg   <= 16'd0;
            normal_steps_reg  <= 7'd64;
            quarter_whole_reg <= 24'd1000;
            quarter_frac_reg  <= 16'd0;
            quarter_steps_reg <= 7'd16;
            modulus_reg       <= 16'd1000;
            chirp_count_reg   <= 8'd128;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                cstep_pkg::CFG_NORMAL_WHOLE:     normal_whole_reg  <= cfg_data;
                cstep_pkg::CFG_NORMAL_FRACTION:  normal_frac_reg   <= cfg_data[15:0];
                cstep_pkg::CFG_NORMAL_STEPS:     normal_steps_reg  <= cfg_data[6:0];
                cstep_pkg::CFG_QUARTER_WHOLE:    quarter_whole_reg <= cfg_data;
                cstep_pkg::CFG_QUARTER_FRACTION: quarter_frac_reg  <= cfg_data[15:0];
                cstep_pkg::CFG_QUARTER_STEPS:    quarter_steps_reg <= cfg_data[6:0];
                cstep_pkg::CFG_FRACTION_MOD:     modulus_reg       <= cfg_data[15:0];
                cstep_pkg::CFG_CHIRP_COUNT:      chirp_count_reg   <= cfg_data[7:0];
            endcase
        end
    end

endmodule
